// ----- hw/rtl/i2a_pkg.sv -----
package i2a_pkg;

    localparam int unsigned C_VALUE_W   = 32;
    localparam int unsigned C_CMD_W     = 2;
    localparam int unsigned C_CHAR_W    = 8;
    localparam int unsigned C_DIGIT_W   = 4;
    localparam int unsigned C_NUM_DIG   = 11;
    localparam int unsigned C_DIG_BUS_W = C_NUM_DIG * C_DIGIT_W;
    localparam int unsigned C_LEFT_W    = $clog2(C_NUM_DIG + 1);
    localparam int unsigned C_BIT_W     = $clog2(C_VALUE_W);

    typedef enum logic [C_CMD_W-1:0] {
        CMD_UDEC = 2'd0,
        CMD_SDEC = 2'd1,
        CMD_OCT  = 2'd2,
        CMD_HEX  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_PRE  = 5'b00100,
        S_SKIP = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    localparam logic [C_CHAR_W-1:0] C_CH_ZERO  = 8'h30;
    localparam logic [C_CHAR_W-1:0] C_CH_UPA   = 8'h41;
    localparam logic [C_CHAR_W-1:0] C_CH_MINUS = 8'h2D;
    localparam logic [C_CHAR_W-1:0] C_CH_X     = 8'h78;

    // Upper-case digit table "0123456789ABCDEF".
    function automatic logic [C_CHAR_W-1:0] digit_char(input logic [C_DIGIT_W-1:0] d);
        logic [C_CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = C_CH_ZERO + {4'd0, d};
        end else begin
            c = C_CH_UPA + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Converts one 32-bit value per request into ASCII text, most significant
// character first, one character per output request, with o_last marking the
// final character. i_command selects unsigned decimal, signed decimal (a
// leading minus, then the two's complement magnitude), octal, or hexadecimal
// with a "0x" prefix; digits are upper case and zero always prints as a
// single '0'. A request is taken whenever o_stall is low, which is the case
// only while no conversion is in progress. Decimal requests run through a
// bit-serial double-dabble converter that consumes one value bit per cycle;
// octal and hex digits are picked straight from the value. After that,
// leading zero digits are dropped one per cycle, and then each character is
// emitted as soon as the output register is free, so a downstream stall
// holds both the prefix and the digits.
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [C_CMD_W-1:0]   i_command,
    input  logic [C_VALUE_W-1:0] i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [C_CHAR_W-1:0]  o_character,
    output logic                 o_last
);

    t_state                   r_state, n_state;
    logic [C_VALUE_W-1:0]     r_mag, n_mag;
    logic [C_DIG_BUS_W-1:0]   r_dig, n_dig;
    logic [C_BIT_W-1:0]       r_bit, n_bit;
    logic [C_LEFT_W-1:0]      r_left, n_left;
    logic [1:0]               r_pre_cnt, n_pre_cnt;
    logic                     r_pre_hex, n_pre_hex;
    logic                     r_ovalid, n_ovalid;
    logic [C_CHAR_W-1:0]      r_char, n_char;
    logic                     r_last, n_last;

    logic                     accept;
    logic                     slot_free;
    t_cmd                     cmd;
    logic [C_VALUE_W:0]       val_ext;
    logic [C_DIG_BUS_W-1:0]   oct_dig;
    logic [C_DIG_BUS_W-1:0]   hex_dig;
    logic [C_DIG_BUS_W-1:0]   bcd_adj;
    logic [C_DIGIT_W-1:0]     top_dig;

    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && (r_state == S_IDLE);
    assign slot_free   = !r_ovalid || !i_stall;
    assign cmd         = t_cmd'(i_command);
    assign val_ext     = {1'b0, i_value};
    assign top_dig     = r_dig[C_DIG_BUS_W-1 -: C_DIGIT_W];
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // Octal and hex digits are plain bit groups of the value.
    always_comb begin
        oct_dig = '0;
        hex_dig = '0;
        for (int k = 0; k < C_NUM_DIG; k++) begin
            oct_dig[k*C_DIGIT_W +: C_DIGIT_W] = {1'b0, val_ext[k*3 +: 3]};
        end
        for (int k = 0; k < C_VALUE_W / C_DIGIT_W; k++) begin
            hex_dig[k*C_DIGIT_W +: C_DIGIT_W] = i_value[k*C_DIGIT_W +: C_DIGIT_W];
        end
    end

    // Double-dabble correction: every BCD digit of five or more gets three
    // added before the next shift, so the shift carries correctly into the
    // next decimal digit.
    always_comb begin
        for (int k = 0; k < C_NUM_DIG; k++) begin
            if (r_dig[k*C_DIGIT_W +: C_DIGIT_W] >= 4'd5) begin
                bcd_adj[k*C_DIGIT_W +: C_DIGIT_W] = r_dig[k*C_DIGIT_W +: C_DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[k*C_DIGIT_W +: C_DIGIT_W] = r_dig[k*C_DIGIT_W +: C_DIGIT_W];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_dig     = r_dig;
        n_bit     = r_bit;
        n_left    = r_left;
        n_pre_cnt = r_pre_cnt;
        n_pre_hex = r_pre_hex;
        n_ovalid  = r_ovalid && i_stall;
        n_char    = r_char;
        n_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_left    = C_LEFT_W'(C_NUM_DIG);
                    n_bit     = C_BIT_W'(C_VALUE_W - 1);
                    n_pre_hex = 1'b0;
                    n_pre_cnt = 2'd0;
                    n_mag     = i_value;
                    n_dig     = '0;
                    unique case (cmd)
                        CMD_UDEC: begin
                            n_state = S_CONV;
                        end
                        CMD_SDEC: begin
                            n_state = S_CONV;
                            if (i_value[C_VALUE_W-1]) begin
                                n_mag     = ~i_value + 1'b1;
                                n_pre_cnt = 2'd1;
                            end
                        end
                        CMD_OCT: begin
                            n_state = S_PRE;
                            n_dig   = oct_dig;
                        end
                        CMD_HEX: begin
                            n_state   = S_PRE;
                            n_dig     = hex_dig;
                            n_pre_hex = 1'b1;
                            n_pre_cnt = 2'd2;
                        end
                        default: begin
                            n_state = S_CONV;
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_dig = {bcd_adj[C_DIG_BUS_W-2:0], r_mag[C_VALUE_W-1]};
                n_mag = {r_mag[C_VALUE_W-2:0], 1'b0};
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_pre_cnt == 2'd0) begin
                    n_state = S_SKIP;
                end else if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_last    = 1'b0;
                    n_pre_cnt = r_pre_cnt - 1'b1;
                    if (!r_pre_hex) begin
                        n_char = C_CH_MINUS;
                    end else if (r_pre_cnt == 2'd2) begin
                        n_char = C_CH_ZERO;
                    end else begin
                        n_char = C_CH_X;
                    end
                end
            end
            S_SKIP: begin
                // Drop leading zeros, but always keep the final digit.
                if (top_dig == '0 && r_left > C_LEFT_W'(1)) begin
                    n_dig  = {r_dig[C_DIG_BUS_W-C_DIGIT_W-1:0], {C_DIGIT_W{1'b0}}};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_char   = digit_char(top_dig);
                    n_last   = (r_left == C_LEFT_W'(1));
                    n_dig    = {r_dig[C_DIG_BUS_W-C_DIGIT_W-1:0], {C_DIGIT_W{1'b0}}};
                    n_left   = r_left - 1'b1;
                    if (r_left == C_LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_dig     <= n_dig;
        r_bit     <= n_bit;
        r_left    <= n_left;
        r_pre_cnt <= n_pre_cnt;
        r_pre_hex <= n_pre_hex;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import i2a_pkg::*;

    // The run stops here no matter what. The slowest correct run is well
    // under this, even with every character held by a long receiver stall.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // After the last expected character, the block gets this many more
    // cycles to prove that it emits nothing extra.
    localparam int unsigned DRAIN_CYCLES = 100;

    // The first few mismatches are printed. The rest are only counted.
    localparam int unsigned MAX_REPORTS = 10;

    // Upper-case digit glyphs, most significant byte first, so glyph d
    // sits at bits [8*(15-d) +: 8].
    localparam logic [127:0] DIGIT_GLYPHS = "0123456789ABCDEF";

    // One character that the block should emit, with its end-of-number flag.
    typedef struct packed {
        logic [C_CHAR_W-1:0] glyph;
        logic                last;
    } t_text_char;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_valid   = 1'b0;
    logic [C_CMD_W-1:0]   i_command = CMD_UDEC;
    logic [C_VALUE_W-1:0] i_value   = '0;
    logic                 i_stall   = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [C_CHAR_W-1:0]  o_character;
    logic                 o_last;

    // Characters predicted for every accepted request, oldest at the front.
    t_text_char  pending_text[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Knobs for the idle behavior of both sides. Tests turn them off to get
    // stretches of back-to-back traffic with no receiver stall at all.
    bit          gaps_on       = 1'b1;
    bit          stalls_on     = 1'b1;
    int unsigned holdoff_req   = 0;
    int unsigned stall_left    = 0;

    integer_to_ascii_formatter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Hard stop. This guards against a block that never accepts or never
    // finishes a number.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver stall. A hold-off request from a test takes priority and
    // keeps the output stalled for that many cycles. Otherwise, short bursts
    // of stall start at random, and now and then a long one.
    always @(posedge i_clk) begin
        if (holdoff_req != 0) begin
            stall_left  = holdoff_req;
            holdoff_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Output check. Outputs and i_stall are both updated by nonblocking
    // assignments, so the values read here are the ones that held just
    // before this edge. Those are the values that decide the handshake.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_text.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected character 8'h%02h last %0d at cycle %0d",
                             o_character, o_last, cycle_count);
                end
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.glyph || o_last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"mismatch at cycle %0d: expected 8'h%02h last %0d,",
                                  " got 8'h%02h last %0d"},
                                 cycle_count, want.glyph, want.last, o_character, o_last);
                    end
                end
            end
        end
    end

    // Predicts the text for one request and queues it. The digits are
    // produced least significant first by repeated division, then queued in
    // reverse. A zero value still yields one '0' digit. In signed mode, the
    // magnitude is the 32-bit two's complement, so 0x80000000 stays
    // 2147483648.
    function automatic void predict_text(input t_cmd cmd, input logic [C_VALUE_W-1:0] val);
        logic [C_VALUE_W-1:0] mag;
        logic [C_VALUE_W-1:0] radix;
        logic [3:0]           digit_buf [0:C_NUM_DIG-1];
        int                   n;
        mag   = val;
        radix = 32'd10;
        n     = 0;
        case (cmd)
            CMD_SDEC: begin
                if (val[C_VALUE_W-1]) begin
                    pending_text.push_back('{glyph: C_CH_MINUS, last: 1'b0});
                    mag = ~val + 32'd1;
                end
            end
            CMD_OCT: begin
                radix = 32'd8;
            end
            CMD_HEX: begin
                radix = 32'd16;
                pending_text.push_back('{glyph: C_CH_ZERO, last: 1'b0});
                pending_text.push_back('{glyph: C_CH_X, last: 1'b0});
            end
            default: begin
            end
        endcase
        do begin
            digit_buf[n] = 4'(mag % radix);
            mag          = mag / radix;
            n++;
        end while (mag != 0);
        for (int i = n - 1; i >= 0; i--) begin
            pending_text.push_back('{glyph: DIGIT_GLYPHS[8*(15-digit_buf[i]) +: 8],
                                     last: (i == 0)});
        end
    endfunction

    // Offers one request and returns at the edge where it is taken. The
    // valid line stays high on return, so the next call with no gap offers
    // its request without a dead cycle. No time may pass between calls
    // except inside this task, or the same request would be taken twice.
    task automatic send_request(input t_cmd cmd, input logic [C_VALUE_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                9:             gap = $urandom_range(8, 30);
                default:       gap = $urandom_range(1, 3);
            endcase
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        predict_text(cmd, val);
    endtask

    // Zero, all ones, the most negative value and the largest positive one
    // in every mode. This covers the lone '0' digit, the "0x0" hex zero, the
    // minus sign and the eleven-character outputs.
    task automatic test_mode_extremes();
        for (int m = 0; m < 4; m++) begin
            send_request(t_cmd'(m), 32'h0000_0000);
            send_request(t_cmd'(m), 32'hFFFF_FFFF);
            send_request(t_cmd'(m), 32'h8000_0000);
            send_request(t_cmd'(m), 32'h7FFF_FFFF);
        end
    endtask

    // Every glyph of the table appears, along with the step from nine to
    // ten decimal digits and the smallest positive signed value.
    task automatic test_digit_table();
        send_request(CMD_HEX, 32'h0123_4567);
        send_request(CMD_HEX, 32'h89AB_CDEF);
        send_request(CMD_UDEC, 32'd999_999_999);
        send_request(CMD_UDEC, 32'd1_000_000_000);
        send_request(CMD_SDEC, 32'd1);
    endtask

    // Random modes and values. Values are a mix of full-width words, short
    // ones of every length, single bits and small negatives, so that every
    // output length turns up.
    task automatic test_random_traffic(input int unsigned count, input bit with_gaps,
                                       input bit with_stalls);
        logic [C_VALUE_W-1:0] val;
        gaps_on   = with_gaps;
        stalls_on = with_stalls;
        repeat (count) begin
            case ($urandom_range(0, 5))
                0, 1:    val = $urandom;
                2:       val = $urandom >> $urandom_range(0, 31);
                3:       val = 32'd1 << $urandom_range(0, 31);
                4:       val = -32'($urandom_range(1, 1000));
                default: val = $urandom_range(0, 1000);
            endcase
            send_request(t_cmd'($urandom_range(0, 3)), val);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    // The block must fill up and hold its input stall until the output
    // drains. Then it must carry on without losing or repeating a character.
    task automatic test_output_holdoff();
        holdoff_req = 400;
        gaps_on     = 1'b0;
        repeat (10) begin
            send_request(t_cmd'($urandom_range(0, 3)), $urandom);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_mode_extremes();
        test_digit_table();
        test_random_traffic(60, 1'b1, 1'b1);
        test_output_holdoff();
        test_random_traffic(40, 1'b0, 1'b0);
        test_random_traffic(50, 1'b1, 1'b1);

        // Stop offering, let every predicted character arrive, then give
        // the block time to show any extra output.
        i_valid <= 1'b0;
        while (pending_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
